@@ hw/rtl/byte_stack_with_search_top_defines.svh @@
// Assertion macros shared by the byte stack RTL.
`ifndef BYTE_STACK_WITH_SEARCH_TOP_DEFINES_SVH
`define BYTE_STACK_WITH_SEARCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define BSS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bss assertion failed");
// Next-cycle implication, disabled during reset.
`define BSS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bss assertion failed");
`else
`define BSS_ASSERT_IMP(label, clk, rst, ante, cons)
`define BSS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/bss_pkg.sv @@
// Types and constants shared by the byte stack modules.
package bss_pkg;

  localparam int DATA_W   = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = 6;
  localparam int DEPTH_W  = 7;
  localparam int CAP_W    = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_CW    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEARCH
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] value;
    logic              reads_top;
    logic              pops;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [DATA_W-1:0]  data;
    logic [IDX_W-1:0]   found_index;
    logic [DEPTH_W-1:0] depth_used;
    logic               is_empty;
    logic               is_full;
  } result_t;

endpackage

@@ hw/rtl/bss_front.sv @@
// Front stage: accept requests, classify the operation and hold them for the queue.
module bss_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bss_pkg::OP_W-1:0]     op,
  input  logic [bss_pkg::DATA_W-1:0]   value,
  output logic                         fq_valid,
  input  logic                         fq_ready,
  output bss_pkg::req_t                fq_req
);

  logic          hold_valid;
  logic          hold_valid_next;
  bss_pkg::req_t hold_req;
  bss_pkg::req_t cls_req;
  logic          accept;

  always_comb begin
    cls_req.op        = bss_pkg::op_t'(op);
    cls_req.value     = value;
    cls_req.reads_top = (cls_req.op == bss_pkg::OP_POP) || (cls_req.op == bss_pkg::OP_PEEK);
    cls_req.pops      = (cls_req.op == bss_pkg::OP_POP);
  end

  assign in_ready = !hold_valid || fq_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hold_valid_next = hold_valid;
    if (accept) begin
      hold_valid_next = 1'b1;
    end else if (fq_ready) begin
      hold_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_req <= cls_req;
    end
  end

  assign fq_valid = hold_valid;
  assign fq_req   = hold_req;

endmodule

@@ hw/rtl/bss_queue.sv @@
// Short request queue between the front stage and the stack engine.
module bss_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bss_pkg::req_t wr_req,
  output logic          rd_valid,
  input  logic          rd_ready,
  output bss_pkg::req_t rd_req
);

  bss_pkg::req_t                   slots [bss_pkg::QUEUE_DEPTH];
  logic [bss_pkg::QUEUE_AW-1:0]    wptr;
  logic [bss_pkg::QUEUE_AW-1:0]    rptr;
  logic [bss_pkg::QUEUE_CW-1:0]    fill;
  logic                            do_wr;
  logic                            do_rd;

  assign wr_ready = (fill != bss_pkg::QUEUE_CW'(bss_pkg::QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_req   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({do_wr, do_rd})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_req;
    end
  end

endmodule

@@ hw/rtl/bss_back.sv @@
// Stack engine: entry memory, depth counter, search scan and result register.
module bss_back #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [bss_pkg::CAP_W-1:0]   capacity,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  bss_pkg::req_t               q_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bss_pkg::result_t            out_res
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > bss_pkg::DEPTH_W) ? CNT_W : bss_pkg::DEPTH_W;

  logic [bss_pkg::DATA_W-1:0] mem [DEPTH];

  bss_pkg::state_t            state;
  bss_pkg::state_t            state_next;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  bss_pkg::req_t              req;
  logic [AW-1:0]              chk_idx;
  logic [AW-1:0]              chk_idx_next;
  logic [bss_pkg::DATA_W-1:0] rd_data;

  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic                       res_load;
  bss_pkg::status_t           res_status;
  logic [bss_pkg::DATA_W-1:0] res_data;
  logic [AW-1:0]              res_idx;
  bss_pkg::result_t           res_next;

  logic [CMP_W-1:0]           cap_ext;
  logic [CMP_W-1:0]           eff_cap;
  logic [CMP_W-1:0]           cnt_ext;
  logic [CMP_W-1:0]           cnt_next_ext;
  logic [CMP_W-1:0]           idx_ext;
  logic                       full_now;
  logic                       slot_free;
  logic                       take;
  logic                       hit;

  assign cap_ext   = CMP_W'(capacity);
  assign eff_cap   = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
  assign cnt_ext   = CMP_W'(count);
  assign full_now  = (cnt_ext >= eff_cap);
  assign slot_free = !out_valid || out_ready;
  assign q_ready   = (state == bss_pkg::S_IDLE) && slot_free;
  assign take      = q_valid && q_ready;
  assign hit       = (rd_data == req.value);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bss_pkg::S_IDLE: begin
        if (take && (count != '0)) begin
          if (q_req.reads_top) begin
            state_next = bss_pkg::S_READ;
          end else if (q_req.op == bss_pkg::OP_SEARCH) begin
            state_next = bss_pkg::S_SEARCH;
          end
        end
      end
      bss_pkg::S_READ: begin
        state_next = bss_pkg::S_IDLE;
      end
      bss_pkg::S_SEARCH: begin
        if (hit || (chk_idx == '0)) begin
          state_next = bss_pkg::S_IDLE;
        end
      end
      default: state_next = bss_pkg::S_IDLE;
    endcase
  end

  // Datapath controls
  always_comb begin
    count_next   = count;
    chk_idx_next = chk_idx;
    wr_en        = 1'b0;
    wr_addr      = count[AW-1:0];
    rd_en        = 1'b0;
    rd_addr      = AW'(count - 1'b1);
    res_load     = 1'b0;
    res_status   = bss_pkg::STAT_OK;
    res_data     = '0;
    res_idx      = '0;
    unique case (state)
      bss_pkg::S_IDLE: begin
        if (take) begin
          unique case (q_req.op)
            bss_pkg::OP_PUSH: begin
              res_load = 1'b1;
              if (full_now) begin
                res_status = bss_pkg::STAT_FULL;
              end else begin
                wr_en      = 1'b1;
                count_next = count + 1'b1;
              end
            end
            bss_pkg::OP_POP, bss_pkg::OP_PEEK: begin
              if (count == '0) begin
                res_load   = 1'b1;
                res_status = bss_pkg::STAT_EMPTY;
              end else begin
                rd_en = 1'b1;
              end
            end
            bss_pkg::OP_SEARCH: begin
              if (count == '0) begin
                res_load   = 1'b1;
                res_status = bss_pkg::STAT_NOT_FOUND;
              end else begin
                rd_en        = 1'b1;
                chk_idx_next = AW'(count - 1'b1);
              end
            end
            default: ;
          endcase
        end
      end
      bss_pkg::S_READ: begin
        res_load = 1'b1;
        res_data = rd_data;
        if (req.pops) begin
          count_next = count - 1'b1;
        end
      end
      bss_pkg::S_SEARCH: begin
        if (hit) begin
          res_load = 1'b1;
          res_idx  = chk_idx;
        end else if (chk_idx == '0) begin
          res_load   = 1'b1;
          res_status = bss_pkg::STAT_NOT_FOUND;
        end else begin
          // step one entry toward the bottom
          rd_en        = 1'b1;
          rd_addr      = chk_idx - 1'b1;
          chk_idx_next = chk_idx - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign cnt_next_ext = CMP_W'(count_next);
  assign idx_ext      = CMP_W'(res_idx);

  always_comb begin
    res_next.status      = res_status;
    res_next.data        = res_data;
    res_next.found_index = idx_ext[bss_pkg::IDX_W-1:0];
    res_next.depth_used  = cnt_next_ext[bss_pkg::DEPTH_W-1:0];
    res_next.is_empty    = (count_next == '0);
    res_next.is_full     = (cnt_next_ext >= eff_cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bss_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req <= q_req;
    end
    chk_idx <= chk_idx_next;
    if (res_load) begin
      out_res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_req.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/byte_stack_with_search_top.sv @@
// Push: the result is loaded as the engine takes it; pop and peek read the entry memory, then
// load the result (at once when empty). Search scans the entry memory top down to a match or
// the bottom entry (at once when empty). Back end takes one push per cycle while the result
// slot is free, and no new request during a pop, peek or search; the sustained rate is set by
// the single read port of the entry memory. Synchronous active-high reset empties the stack and
// restores capacity to 64; entry memory is not cleared, since only written entries are ever read.
`include "byte_stack_with_search_top_defines.svh"

module byte_stack_with_search_top #(
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bss_pkg::OP_W-1:0]         op,
  input  logic [bss_pkg::DATA_W-1:0]       value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bss_pkg::STATUS_W-1:0]     status,
  output logic [bss_pkg::DATA_W-1:0]       data,
  output logic [bss_pkg::IDX_W-1:0]        found_index,
  output logic [bss_pkg::DEPTH_W-1:0]      depth_used,
  output logic                             is_empty,
  output logic                             is_full,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bss_pkg::CAP_W-1:0]        cfg_data
);

  // Capacity register; writes must arrive only while the block is idle (the block does not enforce this).
  logic [bss_pkg::CAP_W-1:0] capacity;

  // Front stage to queue
  logic          fq_valid;
  logic          fq_ready;
  bss_pkg::req_t fq_req;

  // Queue to stack engine
  logic          q_valid;
  logic          q_ready;
  bss_pkg::req_t q_req;

  bss_pkg::result_t res;
  logic             bk_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bss_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Front: accept and classify each request
  bss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .value    (value),
    .fq_valid (fq_valid),
    .fq_ready (fq_ready),
    .fq_req   (fq_req)
  );

  // Decouple the front from the engine so each can stall alone
  bss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_req   (fq_req),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_req   (q_req)
  );

  // Back: carry out the request against the entry memory
  bss_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign bk_take = q_valid && q_ready;

  // Break the result out onto its ports
  assign status      = res.status;
  assign data        = res.data;
  assign found_index = res.found_index;
  assign depth_used  = res.depth_used;
  assign is_empty    = res.is_empty;
  assign is_full     = res.is_full;

  // A rejected push always reports a full stack
  `BSS_ASSERT_IMP(a_full_flag, clk, rst, out_valid && (status == bss_pkg::STAT_FULL), is_full)
  // A failed pop or peek reports an empty stack and no data
  `BSS_ASSERT_IMP(a_empty_flag, clk, rst, out_valid && (status == bss_pkg::STAT_EMPTY),
                  is_empty && (data == '0))
  // The engine never takes a request while an undelivered result holds the slot
  `BSS_ASSERT_IMP(a_slot_free, clk, rst, bk_take, !out_valid || out_ready)
  // Hold a waiting result steady until the receiver takes it
  `BSS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(res))

endmodule
